// ===== design/reply_string_watcher_assert.svh =====
// ----------------------------------------------------------------------------
// reply string watcher assertion macros
// Shared shorthand for the concurrent checks of the watcher.
// ----------------------------------------------------------------------------
`ifndef REPLY_STRING_WATCHER_ASSERT_SVH
`define REPLY_STRING_WATCHER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define RSW_ASSERT_NOW(label, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (prop)) \
    else $error("reply_string_watcher: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define RSW_ASSERT_NEXT(label, trig, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
    else $error("reply_string_watcher: next-cycle check failed");

`endif

// ===== design/rsw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsw_pkg
// Types and constants of the reply string watcher.
// ----------------------------------------------------------------------------
package rsw_pkg;

  // wait phase, also reported as status
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_DRAIN   = 3'd2,
    PH_OK      = 3'd3,
    PH_TIMEOUT = 3'd4,
    PH_FULL    = 3'd5
  } phase_t;

  // operation codes of an input beat
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_POLL  = 2'd2
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PATTERN = 2'd0,
    REG_LENGTH  = 2'd1,
    REG_TIMEOUT = 2'd2
  } reg_index_t;

  localparam int CFG_DATA_W   = 64;
  localparam int LENGTH_W     = 4;
  localparam int TIMEOUT_W    = 16;
  localparam int COUNT_OUT_W  = 6;
  localparam int ELAPSED_W    = 17;

  localparam logic [7:0]           NEWLINE       = 8'h0A;
  localparam logic [ELAPSED_W-1:0] WAIT_STEP_MS  = 17'd4;
  localparam logic [ELAPSED_W-1:0] DRAIN_STEP_MS = 17'd2;

  // one result beat, status in the low bits
  typedef struct packed {
    logic [ELAPSED_W-1:0]   elapsed_ms;
    logic [COUNT_OUT_W-1:0] stored_count;
    phase_t                 status;
  } result_t;

endpackage

// ===== design/reply_string_watcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reply_string_watcher
// Watches received bytes for an expected reply string, with a poll timeout.
// ----------------------------------------------------------------------------
// The watcher takes one beat per clock cycle while s_tready is high and returns
// exactly one result beat for each accepted beat. The whole update of a beat (the
// counters, the shift of the receive window and the compare of the window
// against the pattern at every possible length) is combinational between
// the state registers and the result register. A two-slot output stage
// (result register plus skid register) lets the input keep flowing for one
// beat while the downstream side stalls; s_tready drops only when both slots
// are full. No clearing pass is needed after reset.
`include "reply_string_watcher_assert.svh"

module reply_string_watcher #(
  parameter int STORE_DEPTH = 64,
  parameter int PATTERN_MAX = 8
) (
  input  logic        clk,
  input  logic        rst,
  // input beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_tuser,   // [1:0] operation
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [2:0] status, [8:3] stored_count, [25:9] elapsed_ms
  // configuration writes
  input  logic        cfg_write,
  input  rsw_pkg::reg_index_t cfg_index,
  input  logic [rsw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rsw_pkg::*;

  localparam int CNT_W = $clog2(STORE_DEPTH);
  localparam int PAT_W = 8 * PATTERN_MAX;
  localparam int SEL_W = $clog2(PATTERN_MAX + 1);
  localparam logic [CNT_W-1:0]    CNT_LIMIT = CNT_W'(STORE_DEPTH - 1);
  localparam logic [LENGTH_W-1:0] LEN_LIMIT = LENGTH_W'(PATTERN_MAX);

  // configuration registers
  logic [PAT_W-1:0]     reply_pattern;
  logic [LENGTH_W-1:0]  reply_length;
  logic [TIMEOUT_W-1:0] timeout_ms;

  // wait state
  phase_t               phase, phase_next;
  logic [CNT_W-1:0]     byte_count, byte_count_next;
  logic [ELAPSED_W-1:0] elapsed_time, elapsed_time_next;
  logic [PAT_W-1:0]     recent_window, recent_window_next;
  logic                 zero_seen, zero_seen_next;

  // output stage
  logic    out_valid, skid_valid;
  result_t out_data, skid_data, result_next;

  // match path
  logic [PAT_W-1:0]     window_shift;
  logic [CNT_W-1:0]     count_inc;
  logic                 zero_new;
  logic [LENGTH_W-1:0]  len_clamped;
  logic [SEL_W-1:0]     len_sel;
  logic [PATTERN_MAX:0] hit_len;
  logic                 hit;
  logic [ELAPSED_W-1:0] elapsed_wait, elapsed_drain;

  logic accept;
  op_t  op;

  assign op       = op_t'(s_tuser);
  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'd0, out_data};

  // configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_pattern <= '0;
      reply_length  <= '0;
      timeout_ms    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN: reply_pattern <= cfg_data[PAT_W-1:0];
        REG_LENGTH:  reply_length  <= cfg_data[LENGTH_W-1:0];
        REG_TIMEOUT: timeout_ms    <= cfg_data[TIMEOUT_W-1:0];
        default:     ;
      endcase
    end
  end

  // window after taking the received byte, compared at every length
  always_comb begin
    logic ok;
    window_shift = {recent_window[PAT_W-9:0], s_tdata};
    count_inc    = byte_count + 1'b1;
    zero_new     = zero_seen || (s_tdata == 8'd0);
    len_clamped  = (reply_length > LEN_LIMIT) ? LEN_LIMIT : reply_length;
    len_sel      = SEL_W'(len_clamped);
    hit_len[0]   = 1'b1;
    for (int l = 1; l <= PATTERN_MAX; l++) begin
      ok = 1'b1;
      for (int i = 0; i < l; i++) begin
        ok = ok && (reply_pattern[8*i +: 8] == window_shift[8*(l-1-i) +: 8]);
      end
      hit_len[l] = ok;
    end
    hit = (len_clamped == '0) ||
          (!zero_new && (32'(count_inc) >= 32'(len_clamped)) && hit_len[len_sel]);
  end

  assign elapsed_wait  = elapsed_time + WAIT_STEP_MS;
  assign elapsed_drain = elapsed_time + DRAIN_STEP_MS;

  // next state of the wait
  always_comb begin
    phase_next         = phase;
    byte_count_next    = byte_count;
    elapsed_time_next  = elapsed_time;
    recent_window_next = recent_window;
    zero_seen_next     = zero_seen;
    unique case (op)
      OP_START: begin
        phase_next         = PH_WAIT;
        byte_count_next    = '0;
        elapsed_time_next  = '0;
        recent_window_next = '0;
        zero_seen_next     = 1'b0;
      end
      OP_BYTE: begin
        if (phase == PH_WAIT) begin
          byte_count_next    = count_inc;
          recent_window_next = window_shift;
          zero_seen_next     = zero_new;
          if (hit) begin
            phase_next = (s_tdata == NEWLINE) ? PH_OK : PH_DRAIN;
          end else if (count_inc >= CNT_LIMIT) begin
            phase_next = PH_FULL;
          end
        end else if (phase == PH_DRAIN) begin
          if (byte_count < CNT_LIMIT) begin
            byte_count_next = count_inc;
          end
          if (s_tdata == NEWLINE) begin
            phase_next = PH_OK;
          end
        end
      end
      OP_POLL: begin
        if (phase == PH_WAIT) begin
          elapsed_time_next = elapsed_wait;
          if (elapsed_wait > ELAPSED_W'(timeout_ms)) begin
            phase_next = PH_TIMEOUT;
          end
        end else if (phase == PH_DRAIN) begin
          elapsed_time_next = elapsed_drain;
          if (elapsed_drain > ELAPSED_W'(timeout_ms)) begin
            phase_next = PH_OK;
          end
        end
      end
      default: ;
    endcase
    result_next.elapsed_ms   = elapsed_time_next;
    result_next.stored_count = COUNT_OUT_W'(byte_count_next);
    result_next.status       = phase_next;
  end

  // state registers, updated on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_count    <= '0;
      elapsed_time  <= '0;
      recent_window <= '0;
      zero_seen     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_count    <= byte_count_next;
      elapsed_time  <= elapsed_time_next;
      recent_window <= recent_window_next;
      zero_seen     <= zero_seen_next;
    end
  end

  // result register and skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_valid && !m_tready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (m_tready) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  // payload of the output stage
  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_valid && !m_tready) begin
        skid_data <= result_next;
      end else begin
        out_data <= result_next;
      end
    end else if (m_tready && skid_valid) begin
      out_data <= skid_data;
    end
  end

  // checks
  `RSW_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  `RSW_ASSERT_NEXT(a_stall_fills_skid, accept && out_valid && !m_tready, skid_valid)
  `RSW_ASSERT_NOW(a_wait_below_limit, phase == PH_WAIT, byte_count < CNT_LIMIT)
  `RSW_ASSERT_NOW(a_count_in_range, 1'b1, byte_count <= CNT_LIMIT)

endmodule

// ===== sim/reply_watch_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reply_watch_checker
// Watches the input, result and register ports of the reply string watcher.
// It keeps its own copy of the wait state and the pattern settings, predicts
// one result for every accepted input beat and compares each result beat,
// field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module reply_watch_checker #(
  parameter int STORE_DEPTH = 64,
  parameter int PATTERN_MAX = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  logic [1:0]                     s_tuser,   // [1:0] operation
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [31:0]                    m_tdata,   // [2:0] status, [8:3] count, [25:9] elapsed
  input  logic                           cfg_write,
  input  rsw_pkg::reg_index_t            cfg_index,
  input  logic [rsw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             pending,
  output int                             mismatches
);
  import rsw_pkg::*;

  // register copies
  logic [8*PATTERN_MAX-1:0] want_pattern;
  logic [LENGTH_W-1:0]      want_len;
  logic [TIMEOUT_W-1:0]     limit_ms;

  // wait state copy
  phase_t                   watch_phase;
  int                       rx_count;
  int                       idle_ms;
  logic [8*PATTERN_MAX-1:0] rx_window;
  logic                     nul_seen;

  result_t results_due[$];

  // does the tail of the receive window hold the reply
  function automatic bit tail_matches();
    int n;
    n = (want_len > PATTERN_MAX) ? PATTERN_MAX : int'(want_len);
    if (n == 0) return 1'b1;
    if (nul_seen || rx_count < n) return 1'b0;
    for (int i = 0; i < n; i++)
      if (want_pattern[8*i +: 8] != rx_window[8*(n-1-i) +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // apply one input beat to the wait state and report the state after it
  function automatic result_t advance_watch(logic [1:0] op, logic [7:0] rx);
    result_t r;
    case (op)
      OP_START: begin
        watch_phase = PH_WAIT;
        rx_count    = 0;
        idle_ms     = 0;
        rx_window   = '0;
        nul_seen    = 1'b0;
      end
      OP_BYTE: begin
        if (watch_phase == PH_WAIT) begin
          rx_count++;
          rx_window = {rx_window[8*PATTERN_MAX-9:0], rx};
          if (rx == 8'h00) nul_seen = 1'b1;
          if (tail_matches()) watch_phase = (rx == NEWLINE) ? PH_OK : PH_DRAIN;
          else if (rx_count >= STORE_DEPTH - 1) watch_phase = PH_FULL;
        end else if (watch_phase == PH_DRAIN) begin
          // drained bytes stop counting once the store is full
          if (rx_count < STORE_DEPTH - 1) rx_count++;
          if (rx == NEWLINE) watch_phase = PH_OK;
        end
      end
      OP_POLL: begin
        if (watch_phase == PH_WAIT) begin
          idle_ms += int'(WAIT_STEP_MS);
          if (idle_ms > limit_ms) watch_phase = PH_TIMEOUT;
        end else if (watch_phase == PH_DRAIN) begin
          // running out of time while draining still counts as success
          idle_ms += int'(DRAIN_STEP_MS);
          if (idle_ms > limit_ms) watch_phase = PH_OK;
        end
      end
      default: ;
    endcase
    r.status       = watch_phase;
    r.stored_count = rx_count[COUNT_OUT_W-1:0];
    r.elapsed_ms   = idle_ms[ELAPSED_W-1:0];
    return r;
  endfunction

  // compare result beats, then predict from input beats, then track registers
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      want_pattern = '0;
      want_len     = '0;
      limit_ms     = '0;
      watch_phase  = PH_IDLE;
      rx_count     = 0;
      idle_ms      = 0;
      rx_window    = '0;
      nul_seen     = 1'b0;
      results_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(result_t)-1:0];
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with none expected, expected none, actual %0d/%0d/%0d",
                   $time, got.status, got.stored_count, got.elapsed_ms);
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, got.status);
          end
          if (got.stored_count !== want.stored_count) begin
            mismatches++;
            $display("%0t: stored_count expected %0d actual %0d",
                     $time, want.stored_count, got.stored_count);
          end
          if (got.elapsed_ms !== want.elapsed_ms) begin
            mismatches++;
            $display("%0t: elapsed_ms expected %0d actual %0d",
                     $time, want.elapsed_ms, got.elapsed_ms);
          end
        end
      end
      if (s_tvalid && s_tready) results_due.push_back(advance_watch(s_tuser, s_tdata));
      if (cfg_write) begin
        case (cfg_index)
          REG_PATTERN: want_pattern = cfg_data[8*PATTERN_MAX-1:0];
          REG_LENGTH:  want_len     = cfg_data[LENGTH_W-1:0];
          REG_TIMEOUT: limit_ms     = cfg_data[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= results_due.size();
  end

endmodule

// ===== sim/reply_string_watcher_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reply_string_watcher_test
// Drives the reply string watcher with directed reply scenarios, one long
// poll wait and phases of random replies, noise and store-filling runs
// under several pattern settings, with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module reply_string_watcher_test;
  import rsw_pkg::*;

  localparam int STORE_DEPTH  = 64;
  localparam int PATTERN_MAX  = 8;
  localparam int RANDOM_BEATS = 1100;
  localparam int PHASE_BEATS  = 150;
  localparam int LONG_POLLS   = 40;
  localparam int MAX_IDLE     = 17;
  localparam int CHOKE_CYCLES = 90;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = 8'h00;
  logic [1:0]            s_tuser   = OP_START;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [31:0]           m_tdata;
  logic                  cfg_write = 1'b0;
  reg_index_t            cfg_index = REG_PATTERN;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int                    idle_max      = MAX_IDLE;
  int                    beats_sent    = 0;
  int                    results_taken = 0;
  int                    pending;
  int                    mismatch_total;
  logic [63:0]           cur_pattern   = '0;
  int                    cur_len       = 0;

  reply_string_watcher #(
    .STORE_DEPTH(STORE_DEPTH),
    .PATTERN_MAX(PATTERN_MAX)
  ) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  reply_watch_checker #(
    .STORE_DEPTH(STORE_DEPTH),
    .PATTERN_MAX(PATTERN_MAX)
  ) i_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .mismatches(mismatch_total)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, with a long hold-off now and then
  initial begin
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = (idle_max == 0) ? 0 : int'($urandom_range(idle_max, 0));
      if (results_taken % 300 == 150) hold = CHOKE_CYCLES;
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      results_taken++;
    end
  end

  // offer one input beat after a random gap and wait for it to be taken
  task automatic offer_beat(input logic [1:0] op, input logic [7:0] data);
    int gap;
    gap = (idle_max == 0) ? 0 : int'($urandom_range(idle_max, 0));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  // stop offering and wait until every result has come back
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers, only while the block is idle
  task automatic program_watch(input logic [63:0] pattern, input logic [3:0] length,
                               input logic [15:0] limit);
    cfg_write <= 1'b1;
    cfg_index <= REG_PATTERN;
    cfg_data  <= pattern;
    @(posedge clk);
    cfg_index <= REG_LENGTH;
    cfg_data  <= CFG_DATA_W'(length);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT;
    cfg_data  <= CFG_DATA_W'(limit);
    @(posedge clk);
    cfg_write   <= 1'b0;
    cur_pattern = pattern;
    cur_len     = int'(length);
  endtask

  // stimulus and verdict
  initial begin
    logic [63:0] pat;
    logic [15:0] limit;
    logic [7:0]  b;
    int          len_code;
    int          eff_len;
    int          kind;
    int          pick;
    int          n;
    int          start_beats;
    int          phase_mark;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // two-character reply "OK" with a short limit
    program_watch(64'h4B4F, 4'd2, 16'd20);
    offer_beat(OP_BYTE, 8'h41);       // ignored before any start
    offer_beat(OP_UNUSED, 8'hC3);     // unused operation code
    offer_beat(OP_START, 8'h5A);
    offer_beat(OP_BYTE, 8'h4F);
    offer_beat(OP_BYTE, 8'h4B);       // match, draining
    offer_beat(OP_POLL, 8'hA5);
    offer_beat(OP_BYTE, 8'hFF);
    offer_beat(OP_BYTE, NEWLINE);     // success
    offer_beat(OP_POLL, 8'h00);       // ignored after success
    // a zero byte blocks the match, then the wait times out
    offer_beat(OP_START, 8'h00);
    offer_beat(OP_BYTE, 8'h00);
    offer_beat(OP_BYTE, 8'h4F);
    offer_beat(OP_BYTE, 8'h4B);
    repeat (6) offer_beat(OP_POLL, 8'hFF);
    settle();

    // empty pattern: first byte matches; newline match succeeds at once
    program_watch('1, 4'd0, 16'd0);
    offer_beat(OP_START, 8'hFF);
    offer_beat(OP_BYTE, NEWLINE);
    offer_beat(OP_START, 8'h00);
    offer_beat(OP_BYTE, 8'h55);
    offer_beat(OP_POLL, 8'hAA);       // limit passed while draining
    settle();

    // full-width pattern, length over the maximum
    program_watch('1, 4'd15, 16'd150);
    offer_beat(OP_START, 8'h00);
    repeat (8) offer_beat(OP_BYTE, 8'hFF);
    offer_beat(OP_BYTE, NEWLINE);
    // long wait: poll without gaps until the limit is passed
    idle_max = 0;
    offer_beat(OP_START, 8'h00);
    repeat (LONG_POLLS) offer_beat(OP_POLL, 8'h00);
    idle_max = MAX_IDLE;
    settle();

    // random phases, each under a fresh setting
    start_beats = beats_sent;
    while (beats_sent - start_beats < RANDOM_BEATS) begin
      len_code = $urandom_range(9, 0);
      if (len_code == 9) len_code = $urandom_range(15, 9);
      pat = {$urandom(), $urandom()};
      for (int i = 0; i < 8; i++) begin
        pick = $urandom_range(19, 0);
        if (pick == 0) pat[8*i +: 8] = 8'h00;
        else if (pick < 4) pat[8*i +: 8] = NEWLINE;
      end
      case ($urandom_range(3, 0))
        0:       limit = 16'($urandom_range(12, 0));
        1:       limit = 16'($urandom_range(120, 13));
        2:       limit = 16'($urandom_range(65535, 0));
        default: limit = 16'hFFFF;
      endcase
      program_watch(pat, 4'(len_code), limit);
      eff_len = (cur_len > PATTERN_MAX) ? PATTERN_MAX : cur_len;

      phase_mark = beats_sent;
      while (beats_sent - phase_mark < PHASE_BEATS) begin
        idle_max = ($urandom_range(4, 0) == 0) ? 0 : MAX_IDLE;
        kind = $urandom_range(19, 0);
        if (kind < 14) begin
          // well-formed reply: noise, pattern, trailing bytes, newline
          offer_beat(OP_START, 8'($urandom_range(255, 0)));
          n = $urandom_range(4, 0);
          repeat (n) begin
            if ($urandom_range(3, 0) == 0) offer_beat(OP_POLL, 8'($urandom_range(255, 0)));
            else offer_beat(OP_BYTE, 8'($urandom_range(255, 0)));
          end
          for (int i = 0; i < eff_len; i++) begin
            if ($urandom_range(6, 0) == 0) offer_beat(OP_POLL, 8'($urandom_range(255, 0)));
            offer_beat(OP_BYTE, cur_pattern[8*i +: 8]);
          end
          // a long tail drives the drain past the store limit
          n = (kind == 13) ? STORE_DEPTH + 2 : $urandom_range(5, 0);
          repeat (n) begin
            b = 8'($urandom_range(255, 0));
            if (b == NEWLINE) b = ~b;
            if (kind != 13 && $urandom_range(3, 0) == 0) offer_beat(OP_POLL, b);
            else offer_beat(OP_BYTE, b);
          end
          if ($urandom_range(4, 0) != 0) offer_beat(OP_BYTE, NEWLINE);
        end else if (kind == 14) begin
          // no reply before the store fills
          offer_beat(OP_START, 8'($urandom_range(255, 0)));
          repeat (STORE_DEPTH + 2) offer_beat(OP_BYTE, 8'($urandom_range(255, 1)));
        end else begin
          // noise: any operation, any byte
          n = $urandom_range(12, 1);
          repeat (n) offer_beat(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
        end
      end
      idle_max = MAX_IDLE;
      settle();
    end

    if (mismatch_total == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
